### rtl/core/tri_pkg.sv
// shared constants and codes for the rectangle tween interpolator
package tri_pkg;

	localparam int CoordW   = 16;
	localparam int RectW    = 4 * CoordW;
	localparam int ProgW    = 17;
	localparam int QuoW     = 16;
	localparam int TimeW    = 32;
	localparam int DurW     = 16;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 64;
	localparam int OutDataW = 88;

	localparam logic [ProgW-1:0] ONE_Q16 = 17'h10000;

	localparam logic [ProgW-1:0] STEP_RESET = 17'd655;
	localparam logic [DurW-1:0]  DUR_RESET  = 16'd200;

	// input command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// result kind codes
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// register indexes
	localparam logic [CfgAddrW-1:0] REG_TIMED_MODE = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_BACKWARD   = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_STEP_SIZE  = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_DURATION   = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_START_RECT = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_END_RECT   = 3'd5;

	// handshake between sequencer and a worker unit
	typedef struct packed {
		logic go;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

### rtl/core/tween_rect_interpolator.sv
// top level of the rectangle tween interpolator: sequencer, registers and output stage
// A start transfer (tuser 1) records now_ms, arms the engine and returns the
// starting geometry; each tick transfer (tuser 0) while armed returns the next
// interpolated rectangle, with tlast marking the tick that ends the animation.
// Ticks while disarmed are taken and return nothing. Start and fixed-step
// ticks pass through the shared multiplier, which works through the four
// fields one after another; timed ticks that do not finish first pass
// through the bit-serial divider. One item is in work at a time; the output
// register lets the next item be accepted while a result still waits.
module tween_rect_interpolator
	import tri_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [TimeW-1:0]    s_tdata,  // now_ms
	input  logic                s_tuser,  // cmd
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // progress, rect_x, rect_y, rect_width, rect_height, zero pad
	output logic                m_tuser,  // kind
	output logic                m_tlast,  // done_res
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic             running_q;
	logic [ProgW-1:0] prog_q;
	logic [TimeW-1:0] stamp_q;
	logic [DurW-1:0]  elapsed_q;
	logic             kind_q;
	logic             done_q;
	logic             div_go_q;
	logic             lerp_go_q;

	logic             timed_q;
	logic             backward_q;
	logic [ProgW-1:0] step_q;
	logic [DurW-1:0]  dur_q;
	logic [RectW-1:0] start_rect_q;
	logic [RectW-1:0] end_rect_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic             out_done_q;
	logic [ProgW-1:0] out_prog_q;
	logic [RectW-1:0] out_rect_q;

	unit_req_t        div_req;
	unit_rsp_t        div_rsp;
	unit_req_t        lerp_req;
	unit_rsp_t        lerp_rsp;
	logic [QuoW-1:0]  quotient;
	logic [RectW-1:0] lerp_rect;

	logic             accept;
	logic             out_free;
	logic [ProgW:0]   fwd_sum;
	logic [TimeW-1:0] elapsed;
	logic             time_up;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign fwd_sum  = {1'b0, prog_q} + {1'b0, step_q};
	assign elapsed  = s_tdata - stamp_q;
	assign time_up  = elapsed >= {{(TimeW-DurW){1'b0}}, dur_q};

	assign div_req.go  = div_go_q;
	assign lerp_req.go = lerp_go_q;

	tri_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (elapsed_q),
		.divisor  (dur_q),
		.rsp      (div_rsp),
		.quotient (quotient)
	);

	tri_lerp u_lerp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (lerp_req),
		.prog       (prog_q),
		.start_rect (start_rect_q),
		.end_rect   (end_rect_q),
		.rsp        (lerp_rsp),
		.rect       (lerp_rect)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timed_q      <= 1'b0;
			backward_q   <= 1'b0;
			step_q       <= STEP_RESET;
			dur_q        <= DUR_RESET;
			start_rect_q <= '0;
			end_rect_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TIMED_MODE: timed_q      <= cfg_wdata[0];
				REG_BACKWARD:   backward_q   <= cfg_wdata[0];
				REG_STEP_SIZE:  step_q       <= cfg_wdata[ProgW-1:0];
				REG_DURATION:   dur_q        <= cfg_wdata[DurW-1:0];
				REG_START_RECT: start_rect_q <= cfg_wdata[RectW-1:0];
				REG_END_RECT:   end_rect_q   <= cfg_wdata[RectW-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			prog_q      <= '0;
			stamp_q     <= '0;
			elapsed_q   <= '0;
			kind_q      <= KIND_START;
			done_q      <= 1'b0;
			div_go_q    <= 1'b0;
			lerp_go_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_START;
			out_done_q  <= 1'b0;
			out_prog_q  <= '0;
			out_rect_q  <= '0;
		end else begin
			div_go_q  <= 1'b0;
			lerp_go_q <= 1'b0;
			// a refill in the emit state takes over the flag
			if (out_valid_q && m_tready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_START) begin
							stamp_q   <= s_tdata;
							running_q <= 1'b1;
							prog_q    <= backward_q ? ONE_Q16 : '0;
							kind_q    <= KIND_START;
							done_q    <= 1'b0;
							lerp_go_q <= 1'b1;
							state_q   <= ST_LERP;
						end else if (running_q) begin
							kind_q <= KIND_STEP;
							if (!timed_q) begin
								lerp_go_q <= 1'b1;
								state_q   <= ST_LERP;
								if (!backward_q) begin
									if (fwd_sum >= {1'b0, ONE_Q16}) begin
										prog_q <= ONE_Q16;
										done_q <= 1'b1;
									end else begin
										prog_q <= fwd_sum[ProgW-1:0];
										done_q <= 1'b0;
									end
								end else if (prog_q <= step_q) begin
									prog_q <= '0;
									done_q <= 1'b1;
								end else begin
									prog_q <= prog_q - step_q;
									done_q <= 1'b0;
								end
							end else if (time_up) begin
								prog_q    <= backward_q ? '0 : ONE_Q16;
								done_q    <= 1'b1;
								lerp_go_q <= 1'b1;
								state_q   <= ST_LERP;
							end else begin
								// below the duration, so it fits the divider width
								elapsed_q <= elapsed[DurW-1:0];
								done_q    <= 1'b0;
								div_go_q  <= 1'b1;
								state_q   <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						prog_q    <= backward_q ? ONE_Q16 - {1'b0, quotient} : {1'b0, quotient};
						lerp_go_q <= 1'b1;
						state_q   <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (lerp_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= kind_q;
						out_done_q  <= done_q;
						out_prog_q  <= prog_q;
						out_rect_q  <= lerp_rect;
						if (done_q) begin
							running_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = {(OutDataW-RectW-ProgW)'(0), out_rect_q, out_prog_q};

	// a start result never ends the animation
	a_start_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_START) |-> !m_tlast)
		else $error("start result flagged as finished");

	// a finishing result sits at one end of the range
	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[ProgW-1:0] == '0) || (m_tdata[ProgW-1:0] == ONE_Q16))
		else $error("finishing result not at an end of progress");

	// handing out the finishing result disarms the engine
	a_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_free && done_q |=> !running_q)
		else $error("engine still armed after finishing");

	// divider only reports while the sequencer waits for it
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// interpolation only reports while the sequencer waits for it
	a_lerp_in_lerp: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_rsp.done |-> (state_q == ST_LERP))
		else $error("interpolator finished outside its state");

endmodule

### rtl/core/tri_div.sv
// restoring divider, one quotient bit per cycle, for elapsed*65536/duration
module tri_div
	import tri_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  unit_req_t       req,
	input  logic [DurW-1:0] dividend,
	input  logic [DurW-1:0] divisor,
	output unit_rsp_t       rsp,
	output logic [QuoW-1:0] quotient
);

	logic            busy_q;
	logic            done_q;
	logic [3:0]      cnt_q;
	logic [DurW-1:0] rem_q;
	logic [QuoW-1:0] quo_q;
	logic [DurW:0]   trial;
	logic            fits;

	// dividend is below divisor, so the remainder always fits in DurW bits
	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= dividend;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= DurW'(trial - {1'b0, divisor});
				end else begin
					rem_q <= trial[DurW-1:0];
				end
				quo_q <= {quo_q[QuoW-2:0], fits};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/tri_lerp.sv
// shared multiplier that interpolates the four rectangle fields one after another
module tri_lerp
	import tri_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  unit_req_t        req,
	input  logic [ProgW-1:0] prog,
	input  logic [RectW-1:0] start_rect,
	input  logic [RectW-1:0] end_rect,
	output unit_rsp_t        rsp,
	output logic [RectW-1:0] rect
);

	localparam int ProdW = CoordW + 1 + ProgW + 1;
	localparam int NumW  = ProdW + 1;

	logic                     active_q;
	logic                     phase_q;
	logic                     done_q;
	logic [1:0]               k_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [CoordW-1:0] s_q;
	logic [CoordW-1:0]        res_q [4];

	logic signed [CoordW-1:0] s_k;
	logic signed [CoordW-1:0] e_k;
	logic signed [CoordW:0]   diff;
	logic signed [NumW-1:0]   num;
	logic signed [NumW-1:0]   quo;
	logic signed [NumW-1:0]   quo_rz;

	assign s_k  = start_rect[k_q*CoordW +: CoordW];
	assign e_k  = end_rect[k_q*CoordW +: CoordW];
	assign diff = (CoordW+1)'(e_k) - (CoordW+1)'(s_k);

	// s*65536 + product, then shift with rounding toward zero
	assign num    = {{(NumW-CoordW-16){s_q[CoordW-1]}}, s_q, 16'd0}
	              + NumW'(prod_q);
	assign quo    = num >>> 16;
	assign quo_rz = (num[NumW-1] && (num[15:0] != 16'd0)) ? quo + NumW'(1) : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= 1'b0;
			done_q   <= 1'b0;
			k_q      <= '0;
			prod_q   <= '0;
			s_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				res_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				phase_q  <= 1'b0;
				k_q      <= '0;
			end else if (active_q) begin
				if (!phase_q) begin
					prod_q  <= ProdW'(diff) * ProdW'($signed({1'b0, prog}));
					s_q     <= s_k;
					phase_q <= 1'b1;
				end else begin
					res_q[k_q] <= quo_rz[CoordW-1:0];
					phase_q    <= 1'b0;
					k_q        <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						active_q <= 1'b0;
						done_q   <= 1'b1;
					end
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rect     = {res_q[3], res_q[2], res_q[1], res_q[0]};

endmodule
